// ===== rtl/si_pkg.sv =====
// ----------------------------------------------------------------------------
// si_pkg: shared types and constants of the segment intersection block
// Field widths, register reset value, pipeline flag and result structs, and
// width helpers that every stage derives its datapath from.
// ----------------------------------------------------------------------------
`default_nettype none
package si_pkg;

	localparam int FIELD_W         = 32;
	localparam int MARGIN_W        = 16;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int T_SHIFT         = 16;
	localparam int ONE_Q16         = 65536;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd1;

	// Control bits that ride along with every pair through the pipeline.
	typedef struct packed {
		logic valid;
		logic seg;
		logic miss;
		logic n_t0;
		logic n_t1;
		logic n_px;
		logic n_py;
	} flags_t;

	typedef struct packed {
		logic                      hit;
		logic signed [FIELD_W-1:0] t_ab;
		logic signed [FIELD_W-1:0] t_cd;
		logic signed [FIELD_W-1:0] ix;
		logic signed [FIELD_W-1:0] iy;
		logic                      saturated;
	} res_t;

	// Magnitude of a cross product of two coordinate differences.
	function automatic int magw(input int cw);
		return 2 * cw + 1;
	endfunction

	// Dividend for the parameters: 2*|n|*2^16 + |den|.
	function automatic int ntw(input int cw);
		return magw(cw) + T_SHIFT + 2;
	endfunction

	// Dividend for the point offsets: 2*|n*u| + |den|.
	function automatic int npw(input int cw);
		return magw(cw) + cw + 2;
	endfunction

	// Quotient bits kept; anything at or above 2^qw saturates the output that uses it.
	function automatic int qw(input int cw);
		return cw + 1;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/si_if.sv =====
// ----------------------------------------------------------------------------
// si_if: stream channels of the segment intersection block
// One channel carries segment pairs in, the other carries results out.
// ----------------------------------------------------------------------------
`default_nettype none
interface si_pair_if;
	import si_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] ax;
	logic signed [FIELD_W-1:0] ay;
	logic signed [FIELD_W-1:0] bx;
	logic signed [FIELD_W-1:0] by;
	logic signed [FIELD_W-1:0] cx;
	logic signed [FIELD_W-1:0] cy;
	logic signed [FIELD_W-1:0] dx;
	logic signed [FIELD_W-1:0] dy;
	logic                      segment_only;

	modport source (output valid, ax, ay, bx, by, cx, cy, dx, dy, segment_only,
		input ready);
	modport sink (input valid, ax, ay, bx, by, cx, cy, dx, dy, segment_only,
		output ready);
endinterface

interface si_res_if;
	import si_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic signed [FIELD_W-1:0] t_ab;
	logic signed [FIELD_W-1:0] t_cd;
	logic signed [FIELD_W-1:0] ix;
	logic signed [FIELD_W-1:0] iy;
	logic                      saturated;

	modport source (output valid, hit, t_ab, t_cd, ix, iy, saturated, input ready);
	modport sink (input valid, hit, t_ab, t_cd, ix, iy, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/segment_intersection_top.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_top: 2D line and segment intersection, Q16.16
// Finds where the lines through two segments cross, with parameters, point,
// window test and saturation flag.
// ----------------------------------------------------------------------------
// The block takes one segment pair per clock while its input is ready and
// returns one result per pair, in order. Seven stages form the differences,
// cross products and dividends; four restoring dividers then span
// COORD_WIDTH+2 stages, a first that flags overflow and then one quotient
// bit per stage; two stages apply signs, the window test and saturation, and
// an output register holds the beat. Throughput is one pair per cycle
// whenever the result side keeps up; a two-entry output buffer takes the beat
// in flight when the result side stalls, and the input drops ready once its
// spare slot fills. edge_margin may be rewritten only while no pair is in
// flight; it resets to 1.
`default_nettype none
module segment_intersection_top #(
	parameter int COORD_WIDTH = si_pkg::COORD_WIDTH_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	si_pair_if.sink                     pairs,
	si_res_if.source                    results,
	input  wire                         cfg_we,
	input  wire  [si_pkg::MARGIN_W-1:0] cfg_wdata
);
	import si_pkg::*;

	localparam int CW      = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;
	localparam int MAGW    = magw(CW);
	localparam int NTW     = ntw(CW);
	localparam int NPW     = npw(CW);
	localparam int QW      = qw(CW);
	localparam int DIV_LAT = QW + 1;

	logic [MARGIN_W-1:0] edge_margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_margin_q <= MARGIN_RESET;
		end else if (cfg_we) begin
			edge_margin_q <= cfg_wdata;
		end
	end

	logic en;
	logic main_v_q, skid_v_q;

	// The whole pipeline moves while the spare output slot is free.
	assign en = !skid_v_q;

	flags_t               fr_flags;
	logic signed [CW-1:0] fr_ax, fr_ay;
	logic [NTW-1:0]       nt0, nt1;
	logic [NPW-1:0]       npx, npy;
	logic [MAGW:0]        dd;

	si_front #(.CW(CW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pairs.valid),
		.ax       (pairs.ax),
		.ay       (pairs.ay),
		.bx       (pairs.bx),
		.by       (pairs.by),
		.cx       (pairs.cx),
		.cy       (pairs.cy),
		.dx       (pairs.dx),
		.dy       (pairs.dy),
		.seg_only (pairs.segment_only),
		.flags    (fr_flags),
		.ax_o     (fr_ax),
		.ay_o     (fr_ay),
		.nt0      (nt0),
		.nt1      (nt1),
		.npx      (npx),
		.npy      (npy),
		.dd       (dd)
	);

	logic [QW-1:0] q_t0, q_t1, q_px, q_py;
	logic          o_t0, o_t1, o_px, o_py;

	si_div #(.NW(NTW), .DW(MAGW + 1), .QW(QW)) u_div_t0 (
		.clk(clk), .en(en), .num(nt0), .den(dd), .quo(q_t0), .ovf(o_t0)
	);
	si_div #(.NW(NTW), .DW(MAGW + 1), .QW(QW)) u_div_t1 (
		.clk(clk), .en(en), .num(nt1), .den(dd), .quo(q_t1), .ovf(o_t1)
	);
	si_div #(.NW(NPW), .DW(MAGW + 1), .QW(QW)) u_div_px (
		.clk(clk), .en(en), .num(npx), .den(dd), .quo(q_px), .ovf(o_px)
	);
	si_div #(.NW(NPW), .DW(MAGW + 1), .QW(QW)) u_div_py (
		.clk(clk), .en(en), .num(npy), .den(dd), .quo(q_py), .ovf(o_py)
	);

	// Flags and start point wait alongside the dividers.
	flags_t               fl_d  [DIV_LAT];
	logic signed [CW-1:0] ax_d  [DIV_LAT];
	logic signed [CW-1:0] ay_d  [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) begin
				fl_d[k] <= '0;
			end
		end else if (en) begin
			fl_d[0] <= fr_flags;
			for (int k = 1; k < DIV_LAT; k++) begin
				fl_d[k] <= fl_d[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_d[0] <= fr_ax;
			ay_d[0] <= fr_ay;
			for (int k = 1; k < DIV_LAT; k++) begin
				ax_d[k] <= ax_d[k-1];
				ay_d[k] <= ay_d[k-1];
			end
		end
	end

	logic up_v;
	res_t up_res;

	si_back #(.CW(CW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.flags     (fl_d[DIV_LAT-1]),
		.margin    (edge_margin_q),
		.ax        (ax_d[DIV_LAT-1]),
		.ay        (ay_d[DIV_LAT-1]),
		.q_t0      (q_t0),
		.o_t0      (o_t0),
		.q_t1      (q_t1),
		.o_t1      (o_t1),
		.q_px      (q_px),
		.o_px      (o_px),
		.q_py      (q_py),
		.o_py      (o_py),
		.res_valid (up_v),
		.res       (up_res)
	);

	res_t main_q, skid_q;
	logic push, pop;

	assign push = up_v && en;
	assign pop  = main_v_q && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!main_v_q || pop) begin
				main_v_q <= skid_v_q || push;
				skid_v_q <= 1'b0;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || pop) begin
			main_q <= skid_v_q ? skid_q : up_res;
		end
		if (push && main_v_q && !pop) begin
			skid_q <= up_res;
		end
	end

	assign pairs.ready       = en;
	assign results.valid     = main_v_q;
	assign results.hit       = main_q.hit;
	assign results.t_ab      = main_q.t_ab;
	assign results.t_cd      = main_q.t_cd;
	assign results.ix        = main_q.ix;
	assign results.iy        = main_q.iy;
	assign results.saturated = main_q.saturated;

endmodule
`default_nettype wire

// ===== rtl/si_front.sv =====
// ----------------------------------------------------------------------------
// si_front: differences, cross products and dividends
// Seven stages: differences, products, cross sums, magnitudes, split
// products, their sum, and the rounded-division dividends.
// ----------------------------------------------------------------------------
`default_nettype none
module si_front #(
	parameter int CW = 32
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        en,
	input  wire                        in_valid,
	input  wire  [si_pkg::FIELD_W-1:0] ax,
	input  wire  [si_pkg::FIELD_W-1:0] ay,
	input  wire  [si_pkg::FIELD_W-1:0] bx,
	input  wire  [si_pkg::FIELD_W-1:0] by,
	input  wire  [si_pkg::FIELD_W-1:0] cx,
	input  wire  [si_pkg::FIELD_W-1:0] cy,
	input  wire  [si_pkg::FIELD_W-1:0] dx,
	input  wire  [si_pkg::FIELD_W-1:0] dy,
	input  wire                        seg_only,
	output si_pkg::flags_t             flags,
	output logic signed [CW-1:0]       ax_o,
	output logic signed [CW-1:0]       ay_o,
	output logic [si_pkg::ntw(CW)-1:0] nt0,
	output logic [si_pkg::ntw(CW)-1:0] nt1,
	output logic [si_pkg::npw(CW)-1:0] npx,
	output logic [si_pkg::npw(CW)-1:0] npy,
	output logic [si_pkg::magw(CW):0]  dd
);
	import si_pkg::*;

	localparam int DW   = CW + 1;
	localparam int PW   = 2 * DW;
	localparam int XW   = PW + 1;
	localparam int MAGW = magw(CW);
	localparam int LO   = MAGW / 2;
	localparam int HI   = MAGW - LO;
	localparam int PXW  = MAGW + CW;
	localparam int NTW  = ntw(CW);
	localparam int NPW  = npw(CW);

	logic signed [CW-1:0] axc, ayc, bxc, byc, cxc, cyc, dxc, dyc;

	always_comb begin
		axc = ax[CW-1:0];
		ayc = ay[CW-1:0];
		bxc = bx[CW-1:0];
		byc = by[CW-1:0];
		cxc = cx[CW-1:0];
		cyc = cy[CW-1:0];
		dxc = dx[CW-1:0];
		dyc = dy[CW-1:0];
	end

	flags_t fl_s1, fl_s2, fl_s3, fl_s4, fl_s5, fl_s6, fl_s7;

	logic signed [CW-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3, ax_s4, ay_s4;
	logic signed [CW-1:0] ax_s5, ay_s5, ax_s6, ay_s6, ax_s7, ay_s7;
	logic signed [DW-1:0] ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	logic signed [DW-1:0] ux_s2, uy_s2, ux_s3, uy_s3;
	logic signed [PW-1:0] p_uyvx_s2, p_uxvy_s2, p_vxwy_s2, p_vywx_s2, p_wyux_s2, p_wxuy_s2;
	logic signed [XW-1:0] den_s3, nab_s3, ncd_s3;
	logic [MAGW-1:0]      mden_s4, mnab_s4, mncd_s4;
	logic [CW-1:0]        mux_s4, muy_s4;
	logic [MAGW-1:0]      mden_s5, mnab_s5, mncd_s5;
	logic [LO+CW-1:0]     ppx_lo_s5, ppy_lo_s5;
	logic [HI+CW-1:0]     ppx_hi_s5, ppy_hi_s5;
	logic [MAGW-1:0]      mden_s6, mnab_s6, mncd_s6;
	logic [PXW-1:0]       px_s6, py_s6;
	logic [NTW-1:0]       nt0_s7, nt1_s7;
	logic [NPW-1:0]       npx_s7, npy_s7;
	logic [MAGW:0]        dd_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s1 <= '0;
			fl_s2 <= '0;
			fl_s3 <= '0;
			fl_s4 <= '0;
			fl_s5 <= '0;
			fl_s6 <= '0;
			fl_s7 <= '0;
		end else if (en) begin
			fl_s1 <= '{valid: in_valid, seg: seg_only, default: 1'b0};
			// A zero-length segment on either side can never give a hit.
			fl_s2 <= '{valid: fl_s1.valid, seg: fl_s1.seg,
				miss: (ux_s1 == '0 && uy_s1 == '0) || (vx_s1 == '0 && vy_s1 == '0),
				default: 1'b0};
			fl_s3 <= fl_s2;
			fl_s4 <= '{valid: fl_s3.valid, seg: fl_s3.seg,
				miss: fl_s3.miss || (den_s3 == '0),
				n_t0: nab_s3[XW-1] ^ den_s3[XW-1],
				n_t1: ncd_s3[XW-1] ^ den_s3[XW-1],
				n_px: nab_s3[XW-1] ^ ux_s3[DW-1] ^ den_s3[XW-1],
				n_py: nab_s3[XW-1] ^ uy_s3[DW-1] ^ den_s3[XW-1]};
			fl_s5 <= fl_s4;
			fl_s6 <= fl_s5;
			fl_s7 <= fl_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= axc;
			ay_s1 <= ayc;
			ux_s1 <= DW'(bxc) - DW'(axc);
			uy_s1 <= DW'(byc) - DW'(ayc);
			vx_s1 <= DW'(dxc) - DW'(cxc);
			vy_s1 <= DW'(dyc) - DW'(cyc);
			wx_s1 <= DW'(cxc) - DW'(axc);
			wy_s1 <= DW'(cyc) - DW'(ayc);

			ax_s2     <= ax_s1;
			ay_s2     <= ay_s1;
			ux_s2     <= ux_s1;
			uy_s2     <= uy_s1;
			p_uyvx_s2 <= uy_s1 * vx_s1;
			p_uxvy_s2 <= ux_s1 * vy_s1;
			p_vxwy_s2 <= vx_s1 * wy_s1;
			p_vywx_s2 <= vy_s1 * wx_s1;
			p_wyux_s2 <= wy_s1 * ux_s1;
			p_wxuy_s2 <= wx_s1 * uy_s1;

			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			ux_s3  <= ux_s2;
			uy_s3  <= uy_s2;
			den_s3 <= XW'(p_uyvx_s2) - XW'(p_uxvy_s2);
			nab_s3 <= XW'(p_vxwy_s2) - XW'(p_vywx_s2);
			ncd_s3 <= XW'(p_wyux_s2) - XW'(p_wxuy_s2);

			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
			mden_s4 <= MAGW'(den_s3[XW-1] ? -den_s3 : den_s3);
			mnab_s4 <= MAGW'(nab_s3[XW-1] ? -nab_s3 : nab_s3);
			mncd_s4 <= MAGW'(ncd_s3[XW-1] ? -ncd_s3 : ncd_s3);
			mux_s4  <= CW'(ux_s3[DW-1] ? -ux_s3 : ux_s3);
			muy_s4  <= CW'(uy_s3[DW-1] ? -uy_s3 : uy_s3);

			// The wide numerator is split so that each multiplier stays narrow.
			ax_s5     <= ax_s4;
			ay_s5     <= ay_s4;
			mden_s5   <= mden_s4;
			mnab_s5   <= mnab_s4;
			mncd_s5   <= mncd_s4;
			ppx_lo_s5 <= mnab_s4[LO-1:0] * mux_s4;
			ppy_lo_s5 <= mnab_s4[LO-1:0] * muy_s4;
			ppx_hi_s5 <= mnab_s4[MAGW-1:LO] * mux_s4;
			ppy_hi_s5 <= mnab_s4[MAGW-1:LO] * muy_s4;

			ax_s6   <= ax_s5;
			ay_s6   <= ay_s5;
			mden_s6 <= mden_s5;
			mnab_s6 <= mnab_s5;
			mncd_s6 <= mncd_s5;
			px_s6   <= (PXW'(ppx_hi_s5) << LO) + PXW'(ppx_lo_s5);
			py_s6   <= (PXW'(ppy_hi_s5) << LO) + PXW'(ppy_lo_s5);

			// Rounding to nearest is folded into the dividend: (2n + d) / 2d.
			ax_s7  <= ax_s6;
			ay_s7  <= ay_s6;
			nt0_s7 <= (NTW'(mnab_s6) << (T_SHIFT + 1)) + NTW'(mden_s6);
			nt1_s7 <= (NTW'(mncd_s6) << (T_SHIFT + 1)) + NTW'(mden_s6);
			npx_s7 <= (NPW'(px_s6) << 1) + NPW'(mden_s6);
			npy_s7 <= (NPW'(py_s6) << 1) + NPW'(mden_s6);
			dd_s7  <= (MAGW + 1)'(mden_s6) << 1;
		end
	end

	assign flags = fl_s7;
	assign ax_o  = ax_s7;
	assign ay_o  = ay_s7;
	assign nt0   = nt0_s7;
	assign nt1   = nt1_s7;
	assign npx   = npx_s7;
	assign npy   = npy_s7;
	assign dd    = dd_s7;

endmodule
`default_nettype wire

// ===== rtl/si_div.sv =====
// ----------------------------------------------------------------------------
// si_div: pipelined restoring divider
// One quotient bit per stage, after a first stage that flags quotients of
// 2^QW or more; one division is accepted per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none
module si_div #(
	parameter int NW = 83,
	parameter int DW = 66,
	parameter int QW = 33
) (
	input  wire           clk,
	input  wire           en,
	input  wire  [NW-1:0] num,
	input  wire  [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          ovf
);
	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	logic [RW-1:0] rem_s [QW+1];
	logic [DW-1:0] dv_s  [QW+1];
	logic [QW-1:0] qo_s  [QW+1];
	logic          ov_s  [QW+1];
	logic [RW-1:0] dsh   [QW+1];
	logic          take  [QW+1];

	always_comb begin
		dsh[0]  = '0;
		take[0] = 1'b0;
		for (int k = 1; k <= QW; k++) begin
			dsh[k]  = RW'(dv_s[k-1]) << (QW - k);
			take[k] = rem_s[k-1] >= dsh[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(num);
			dv_s[0]  <= den;
			qo_s[0]  <= '0;
			ov_s[0]  <= RW'(num) >= (RW'(den) << QW);
			for (int k = 1; k <= QW; k++) begin
				rem_s[k] <= take[k] ? rem_s[k-1] - dsh[k] : rem_s[k-1];
				dv_s[k]  <= dv_s[k-1];
				qo_s[k]  <= qo_s[k-1] | (QW'(take[k]) << (QW - k));
				ov_s[k]  <= ov_s[k-1];
			end
		end
	end

	assign quo = qo_s[QW];
	assign ovf = ov_s[QW];

endmodule
`default_nettype wire

// ===== rtl/si_back.sv =====
// ----------------------------------------------------------------------------
// si_back: sign, window test and saturation
// Two stages: signed parameters, window test and point sums, then clamping
// to the coordinate range and zeroing of misses.
// ----------------------------------------------------------------------------
`default_nettype none
module si_back #(
	parameter int CW = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         en,
	input  si_pkg::flags_t              flags,
	input  wire  [si_pkg::MARGIN_W-1:0] margin,
	input  wire  signed [CW-1:0]        ax,
	input  wire  signed [CW-1:0]        ay,
	input  wire  [si_pkg::qw(CW)-1:0]   q_t0,
	input  wire                         o_t0,
	input  wire  [si_pkg::qw(CW)-1:0]   q_t1,
	input  wire                         o_t1,
	input  wire  [si_pkg::qw(CW)-1:0]   q_px,
	input  wire                         o_px,
	input  wire  [si_pkg::qw(CW)-1:0]   q_py,
	input  wire                         o_py,
	output logic                        res_valid,
	output si_pkg::res_t                res
);
	import si_pkg::*;

	localparam int QW   = qw(CW);
	localparam int TW   = QW + 2;
	localparam int SW   = TW + 1;
	localparam int CMPW = (TW > 19) ? TW : 19;
	localparam logic signed [SW-1:0] MAXV = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] MINV = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	// An overflowed quotient stands in as 2^QW, which saturates every use.
	function automatic logic signed [TW-1:0] sval(input logic [QW-1:0] q, input logic o,
		input logic n);
		logic [QW:0] m;
		m = o ? {1'b1, {QW{1'b0}}} : {1'b0, q};
		return n ? -TW'(m) : TW'(m);
	endfunction

	function automatic logic [CW:0] clamp(input logic signed [SW-1:0] x);
		if (x > MAXV) begin
			return {1'b1, MAXV[CW-1:0]};
		end else if (x < MINV) begin
			return {1'b1, MINV[CW-1:0]};
		end
		return {1'b0, x[CW-1:0]};
	endfunction

	logic signed [TW-1:0]   t0, t1, qx, qy;
	logic signed [CMPW-1:0] mg, lim, t0c, t1c;
	logic                   in_win;

	always_comb begin
		t0     = sval(q_t0, o_t0, flags.n_t0);
		t1     = sval(q_t1, o_t1, flags.n_t1);
		qx     = sval(q_px, o_px, flags.n_px);
		qy     = sval(q_py, o_py, flags.n_py);
		mg     = CMPW'(margin);
		lim    = CMPW'(ONE_Q16) - mg;
		t0c    = CMPW'(t0);
		t1c    = CMPW'(t1);
		// A margin above one half leaves no window at all.
		in_win = t0c >= mg && t0c <= lim && t1c >= mg && t1c <= lim;
	end

	logic                 v_s1, miss_s1, v_s2;
	logic signed [SW-1:0] t0_s1, t1_s1, sx_s1, sy_s1;
	res_t                 res_s2;
	logic [CW:0]          c0, c1, cx, cy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= flags.valid;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		c0 = clamp(t0_s1);
		c1 = clamp(t1_s1);
		cx = clamp(sx_s1);
		cy = clamp(sy_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			miss_s1 <= flags.miss || (flags.seg && !in_win);
			t0_s1   <= SW'(t0);
			t1_s1   <= SW'(t1);
			sx_s1   <= SW'(ax) + SW'(qx);
			sy_s1   <= SW'(ay) + SW'(qy);

			if (miss_s1) begin
				res_s2 <= '0;
			end else begin
				res_s2.hit       <= 1'b1;
				res_s2.t_ab      <= FIELD_W'($signed(c0[CW-1:0]));
				res_s2.t_cd      <= FIELD_W'($signed(c1[CW-1:0]));
				res_s2.ix        <= FIELD_W'($signed(cx[CW-1:0]));
				res_s2.iy        <= FIELD_W'($signed(cy[CW-1:0]));
				res_s2.saturated <= c0[CW] | c1[CW] | cx[CW] | cy[CW];
			end
		end
	end

	assign res_valid = v_s2;
	assign res       = res_s2;

endmodule
`default_nettype wire

// ===== rtl/si_checker.sv =====
// ----------------------------------------------------------------------------
// si_checker: port-level checks of the segment intersection block
// Watches the result channel and the input ready, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module si_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               in_ready,
	input wire                               out_valid,
	input wire                               out_ready,
	input wire                               hit,
	input wire signed [si_pkg::FIELD_W-1:0]  t_ab,
	input wire signed [si_pkg::FIELD_W-1:0]  t_cd,
	input wire signed [si_pkg::FIELD_W-1:0]  ix,
	input wire signed [si_pkg::FIELD_W-1:0]  iy,
	input wire                               saturated
);
	import si_pkg::*;

	// A miss carries nothing but zeros.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> t_ab == '0 && t_cd == '0 && ix == '0 && iy == '0
			&& !saturated)
		else $error("miss beat with nonzero fields");

	// The input backs off only when the output buffer is full.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(t_ab) && $stable(ix) && $stable(hit))
		else $error("result beat changed while stalled");

endmodule

bind segment_intersection_top si_checker u_si_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pairs.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.hit       (results.hit),
	.t_ab      (results.t_ab),
	.t_cd      (results.t_cd),
	.ix        (results.ix),
	.iy        (results.iy),
	.saturated (results.saturated)
);
`default_nettype wire

// ===== dv/segment_intersection_top_tb.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_top_tb: stream test of the segment intersection block
// Drives segment pairs under several edge margins and idle patterns, predicts
// every result with exact wide integer arithmetic and checks each result beat
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module segment_intersection_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import si_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 60;
	localparam longint QCLAMP = 64'sd1 << 62;

	typedef logic signed [191:0] wide_t;

	typedef struct {
		logic signed [FIELD_W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
		logic                      seg;
	} pair_t;

	class intersect_board;
		res_t            pending[$];
		int              errors;
		logic [MARGIN_W-1:0] margin;

		function new();
			errors = 0;
			margin = MARGIN_RESET;
		endfunction

		static function wide_t wabs(wide_t x);
			return (x < 0) ? -x : x;
		endfunction

		// Rounded quotient n*2^sh/d, ties away from zero, magnitude clamped.
		static function longint round_div(wide_t n, int sh, wide_t d);
			wide_t  q;
			longint m;
			q = ((wabs(n) << (sh + 1)) + wabs(d)) / (wabs(d) << 1);
			m = (q > wide_t'(QCLAMP)) ? QCLAMP : longint'(q);
			return ((n < 0) != (d < 0)) ? -m : m;
		endfunction

		static function logic signed [31:0] clamp32(longint x, inout logic flag);
			if (x > 64'sd2147483647) begin
				flag = 1'b1;
				return 32'sh7fffffff;
			end
			if (x < -64'sd2147483648) begin
				flag = 1'b1;
				return 32'sh80000000;
			end
			return x[31:0];
		endfunction

		static function res_t predict(pair_t p, logic [MARGIN_W-1:0] mg);
			res_t   r;
			longint ux, uy, vx, vy, wx, wy, t0, t1, qx, qy, m;
			wide_t  den, nab, ncd;
			logic   flag;
			r = '0;
			flag = 1'b0;
			ux = longint'(p.bx) - longint'(p.ax);
			uy = longint'(p.by) - longint'(p.ay);
			vx = longint'(p.dx) - longint'(p.cx);
			vy = longint'(p.dy) - longint'(p.cy);
			wx = longint'(p.cx) - longint'(p.ax);
			wy = longint'(p.cy) - longint'(p.ay);
			if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0)) return r;
			den = wide_t'(uy) * wide_t'(vx) - wide_t'(ux) * wide_t'(vy);
			if (den == 0) return r;
			nab = wide_t'(vx) * wide_t'(wy) - wide_t'(vy) * wide_t'(wx);
			ncd = wide_t'(wy) * wide_t'(ux) - wide_t'(wx) * wide_t'(uy);
			t0 = round_div(nab, T_SHIFT, den);
			t1 = round_div(ncd, T_SHIFT, den);
			if (p.seg) begin
				m = longint'(mg);
				if (!(t0 >= m && t0 <= ONE_Q16 - m && t1 >= m && t1 <= ONE_Q16 - m))
					return r;
			end
			qx = round_div(nab * wide_t'(ux), 0, den);
			qy = round_div(nab * wide_t'(uy), 0, den);
			r.hit = 1'b1;
			r.t_ab = clamp32(t0, flag);
			r.t_cd = clamp32(t1, flag);
			r.ix = clamp32(longint'(p.ax) + qx, flag);
			r.iy = clamp32(longint'(p.ay) + qy, flag);
			r.saturated = flag;
			return r;
		endfunction

		function void note(pair_t p);
			pending.push_back(predict(p, margin));
		endfunction

		function void check(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				$error("result beat with no pair outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, got.hit); errors++;
			end
			if (got.t_ab !== want.t_ab) begin
				$error("t_ab: expected %0d, got %0d", want.t_ab, got.t_ab); errors++;
			end
			if (got.t_cd !== want.t_cd) begin
				$error("t_cd: expected %0d, got %0d", want.t_cd, got.t_cd); errors++;
			end
			if (got.ix !== want.ix) begin
				$error("ix: expected %0d, got %0d", want.ix, got.ix); errors++;
			end
			if (got.iy !== want.iy) begin
				$error("iy: expected %0d, got %0d", want.iy, got.iy); errors++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [MARGIN_W-1:0] cfg_wdata = '0;
	int                  send_idle = 0;
	int                  recv_idle = 0;
	int                  hold_left = 0;
	int                  quiet_cycles = 0;
	intersect_board      board;

	si_pair_if pairs_ch ();
	si_res_if  results_ch ();

	segment_intersection_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pairs    (pairs_ch),
		.results  (results_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	initial begin
		pairs_ch.valid = 1'b0;
		{pairs_ch.ax, pairs_ch.ay, pairs_ch.bx, pairs_ch.by} = '0;
		{pairs_ch.cx, pairs_ch.cy, pairs_ch.dx, pairs_ch.dy} = '0;
		pairs_ch.segment_only = 1'b0;
		results_ch.ready = 1'b0;
	end

	// The result side stalls at random, or for a counted stretch on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			results_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			results_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready) begin
			board.check('{hit: results_ch.hit, t_ab: results_ch.t_ab,
				t_cd: results_ch.t_cd, ix: results_ch.ix, iy: results_ch.iy,
				saturated: results_ch.saturated});
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((pairs_ch.valid && pairs_ch.ready) ||
				(results_ch.valid && results_ch.ready)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic signed [31:0] near_coord(int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic pair_t mk(longint ax, ay, bx, by, cx, cy, dx, dy, logic seg);
		pair_t p;
		p.ax = 32'(ax); p.ay = 32'(ay); p.bx = 32'(bx); p.by = 32'(by);
		p.cx = 32'(cx); p.cy = 32'(cy); p.dx = 32'(dx); p.dy = 32'(dy);
		p.seg = seg;
		return p;
	endfunction

	function automatic logic signed [31:0] edgy_coord();
		case ($urandom_range(0, 3))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			default: return near_coord(1 << 20);
		endcase
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int    kind, k;
		kind = $urandom_range(0, 99);
		p.seg = 1'($urandom_range(0, 1));
		p.ax = near_coord(1 << 19); p.ay = near_coord(1 << 19);
		p.bx = near_coord(1 << 19); p.by = near_coord(1 << 19);
		p.cx = near_coord(1 << 19); p.cy = near_coord(1 << 19);
		p.dx = near_coord(1 << 19); p.dy = near_coord(1 << 19);
		if (kind < 45) begin
			// Ordinary small pairs; many cross inside both segments.
		end else if (kind < 60) begin
			p.ax = $urandom; p.ay = $urandom; p.bx = $urandom; p.by = $urandom;
			p.cx = $urandom; p.cy = $urandom; p.dx = $urandom; p.dy = $urandom;
		end else if (kind < 70) begin
			k = $urandom_range(0, 3) - 1;
			if (k == 0) k = 2;
			p.dx = p.cx + k * (p.bx - p.ax);
			p.dy = p.cy + k * (p.by - p.ay);
		end else if (kind < 78) begin
			p.cx = p.ax + 2 * (p.bx - p.ax); p.cy = p.ay + 2 * (p.by - p.ay);
			p.dx = p.bx; p.dy = p.by;
		end else if (kind < 85) begin
			if ($urandom_range(0, 1)) begin
				p.bx = p.ax; p.by = p.ay;
			end else begin
				p.dx = p.cx; p.dy = p.cy;
			end
		end else if (kind < 93) begin
			p.ax = near_coord(1 << 28); p.ay = near_coord(1 << 28);
			p.bx = p.ax + near_coord(1 << 12); p.by = p.ay + near_coord(1 << 12);
			p.cx = near_coord(1 << 28); p.cy = near_coord(1 << 28);
			p.dx = p.cx + near_coord(1 << 12); p.dy = p.cy + near_coord(1 << 12);
		end else begin
			p.ax = edgy_coord(); p.ay = edgy_coord(); p.bx = edgy_coord();
			p.by = edgy_coord(); p.cx = edgy_coord(); p.cy = edgy_coord();
			p.dx = edgy_coord(); p.dy = edgy_coord();
		end
		return p;
	endfunction

	// Offers one pair from the falling edge and holds it until the beat.
	task automatic send_pair(pair_t p);
		while ($urandom_range(0, 99) < send_idle) begin
			@(negedge clk);
			pairs_ch.valid = 1'b0;
		end
		@(negedge clk);
		pairs_ch.valid = 1'b1;
		pairs_ch.ax = p.ax; pairs_ch.ay = p.ay; pairs_ch.bx = p.bx; pairs_ch.by = p.by;
		pairs_ch.cx = p.cx; pairs_ch.cy = p.cy; pairs_ch.dx = p.dx; pairs_ch.dy = p.dy;
		pairs_ch.segment_only = p.seg;
		do @(posedge clk); while (!pairs_ch.ready);
		board.note(p);
	endtask

	task automatic drain();
		@(negedge clk);
		pairs_ch.valid = 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_margin(logic [MARGIN_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		board.margin = value;
	endtask

	localparam longint ONE = 65536;
	localparam longint MAXC = 64'sd2147483647;
	localparam longint MINC = -64'sd2147483648;

	initial begin
		logic [MARGIN_W-1:0] margins[6];
		int                  phase;
		board = new();
		margins = '{16'd0, 16'd32768, 16'd1, 16'd6554, 16'd32767, 16'd0};
		margins[5] = 16'($urandom_range(0, 32768));
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// Directed pairs at the reset margin.
		send_pair(mk(0, 0, ONE, ONE, 0, ONE, ONE, 0, 1));
		send_pair(mk(0, 0, ONE, ONE, 0, ONE, ONE, 0, 0));
		send_pair(mk(5, 7, 5, 7, 0, ONE, ONE, 0, 0));
		send_pair(mk(0, 0, ONE, ONE, 3 * ONE, 2, 3 * ONE, 2, 0));
		send_pair(mk(0, 0, ONE, 0, 0, ONE, 2 * ONE, ONE, 0));
		send_pair(mk(0, 0, ONE, 0, 2 * ONE, 0, 3 * ONE, 0, 1));
		send_pair(mk(0, 0, ONE, 0, 0, 0, 0, ONE, 1));
		send_pair(mk(0, 0, ONE, 0, 0, 0, 0, ONE, 0));
		send_pair(mk(0, 0, ONE, 0, 5 * ONE, -ONE, 5 * ONE, ONE, 1));
		send_pair(mk(0, 0, ONE, 0, 5 * ONE, -ONE, 5 * ONE, ONE, 0));
		send_pair(mk(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, 0));
		send_pair(mk(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, 1));
		send_pair(mk(MAXC, MAXC, MAXC, MAXC, MINC, MINC, MAXC, MAXC, 0));
		send_pair(mk(0, 0, 1, 0, MAXC, MAXC, MAXC, MAXC - 1, 0));
		send_pair(mk(0, 0, 1, 1, MINC, MAXC, MINC + 1, MAXC, 0));
		send_pair(mk(MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, 1));
		send_pair(mk(0, 0, 3, 1, 1, 0, 0, 1, 1));
		send_pair(mk(0, 0, 3, 0, 1, -1, 2, 2, 0));
		send_pair(mk(-ONE, -ONE, -3 * ONE, ONE, -2 * ONE, -2 * ONE, -2 * ONE, 7, 1));
		send_pair(mk(0, 0, 0, 1, 1, 0, 2, 0, 0));
		drain();

		for (phase = 0; phase < 6; phase++) begin
			write_margin(margins[phase]);
			case (phase % 3)
				0: begin send_idle = 20; recv_idle = 85; end
				1: begin send_idle = 85; recv_idle = 20; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			// A long result-side stall fills the pipeline and backs up the input.
			if (phase == 2) hold_left = 300;
			repeat (125) send_pair(random_pair());
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== segment_intersection_top.f =====
rtl/si_pkg.sv
rtl/si_if.sv
rtl/si_front.sv
rtl/si_div.sv
rtl/si_back.sv
rtl/segment_intersection_top.sv
rtl/si_checker.sv
dv/segment_intersection_top_tb.sv
